@@ hdl/gbn_pkg.sv @@
// Shared types, constants and codes for the Go-Back-N sender sequencer.
package gbn_pkg;

    localparam int SEQ_BITS   = 16;
    localparam int WINDOW_MAX = 8;
    localparam int WIN_W      = 4;
    localparam int BASE_W     = SEQ_BITS + 1;
    localparam int DP_W       = SEQ_BITS + 2;
    localparam int CNT_W      = $clog2(WINDOW_MAX + 1);
    localparam int CFG_IDX_W  = 2;

    localparam logic [1:0] FUNC_START   = 2'd0;
    localparam logic [1:0] FUNC_ACK     = 2'd1;
    localparam logic [1:0] FUNC_TIMEOUT = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd1;

    localparam logic [WIN_W-1:0] WINDOW_RESET = 4'd3;

    typedef struct packed {
        logic [1:0]          func;
        logic [SEQ_BITS-1:0] ack_number;
    } gbn_in_t;

    typedef struct packed {
        logic                frame_valid;
        logic [SEQ_BITS-1:0] frame_number;
        logic                is_resend;
        logic [BASE_W-1:0]   window_base;
        logic                transfer_done;
        logic                last;
    } gbn_out_t;

endpackage

@@ hdl/gbn_alu.sv @@
// Shared add / subtract-compare unit used by the sender sequencer for its arithmetic steps.
module gbn_alu
    import gbn_pkg::*;
(
    input  logic [DP_W-1:0] a,
    input  logic [DP_W-1:0] b,
    input  logic            sub,
    output logic [DP_W-1:0] res,
    output logic            lt
);

    logic [DP_W:0] sum;

    // a - b is a + ~b + 1; a missing carry means a < b
    assign sum = {1'b0, a} + {1'b0, (b ^ {DP_W{sub}})} + {{DP_W{1'b0}}, sub};
    assign res = sum[DP_W-1:0];
    assign lt  = sub & ~sum[DP_W];

endmodule

@@ hdl/gbn_obuf.sv @@
// Output holding register: keeps one result beat until the sink takes it.
module gbn_obuf
    import gbn_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     load,
    input  gbn_out_t load_data,
    output logic     free,
    output logic     out_valid,
    input  logic     out_ready,
    output gbn_out_t out_data
);

    logic     valid_reg;
    logic     valid_next;
    gbn_out_t data_reg;

    assign free       = ~valid_reg | out_ready;
    assign valid_next = load | (valid_reg & ~out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= load_data;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

@@ hdl/go_back_n_arq_sender.sv @@
// Top level of the Go-Back-N sender sequencer: event intake, step sequencer, result output.
//
// Each accepted event (start, ACK, timeout) is worked through by a small sequencer that
// drives one shared 18-bit add/compare unit, one operation per cycle. An ACK runs the
// setup steps increment, clamp, slide base, window limit, total limit, minimum, count
// and done flag; a start begins at window limit, a timeout or an ignored event at total
// limit. Then result beats follow, one per cycle while the sink takes them and one per
// frame issued (at most WINDOW_MAX), or a single status beat when no frame goes out;
// in_ready is high only while the sequencer waits for an event. A finished beat sits in
// an output register, so the next event may be taken while the last beat of the previous
// one still waits. All beats of one event report the base and done flag as they stand
// after that event, and the final beat carries last.
// Configuration writes are always taken and must only be issued while the block idles.
module go_back_n_arq_sender
    import gbn_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  gbn_in_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output gbn_out_t             out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SEQ_BITS-1:0]  cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_A_INC  = 4'd1;
    localparam logic [3:0] S_A_CLP  = 4'd2;
    localparam logic [3:0] S_A_MAX  = 4'd3;
    localparam logic [3:0] S_L_WIN  = 4'd4;
    localparam logic [3:0] S_L_TOT  = 4'd5;
    localparam logic [3:0] S_L_MIN  = 4'd6;
    localparam logic [3:0] S_L_CNT  = 4'd7;
    localparam logic [3:0] S_L_DONE = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;
    localparam logic [3:0] S_STATUS = 4'd10;

    logic [3:0]          state_reg,  state_next;
    logic [BASE_W-1:0]   base_reg,   base_next;
    logic [BASE_W-1:0]   next_reg,   next_next;
    logic                active_reg, active_next;
    logic [DP_W-1:0]     tmp_reg,    tmp_next;
    logic [DP_W-1:0]     lim_reg,    lim_next;
    logic [BASE_W-1:0]   f_reg,      f_next;
    logic [CNT_W-1:0]    cnt_reg,    cnt_next;
    logic                resend_reg, resend_next;
    logic                done_reg,   done_next;
    logic [SEQ_BITS-1:0] total_reg;
    logic [WIN_W-1:0]    window_reg;

    logic [DP_W-1:0] alu_a, alu_b, alu_res;
    logic            alu_sub, alu_lt;
    logic [DP_W-1:0] win_eff;
    logic [DP_W-1:0] base_ext, next_ext, f_ext, tot_ext;
    logic            ob_load, ob_free;
    gbn_out_t        ob_data;

    assign base_ext = {{(DP_W-BASE_W){1'b0}}, base_reg};
    assign next_ext = {{(DP_W-BASE_W){1'b0}}, next_reg};
    assign f_ext    = {{(DP_W-BASE_W){1'b0}}, f_reg};
    assign tot_ext  = {{(DP_W-SEQ_BITS){1'b0}}, total_reg};

    // Clamp the window into 1..WINDOW_MAX
    always_comb
    begin
        if (window_reg == '0)
        begin
            win_eff = DP_W'(1);
        end
        else if ({{(DP_W-WIN_W){1'b0}}, window_reg} > DP_W'(WINDOW_MAX))
        begin
            win_eff = DP_W'(WINDOW_MAX);
        end
        else
        begin
            win_eff = {{(DP_W-WIN_W){1'b0}}, window_reg};
        end
    end

    // Operand select for the shared unit
    always_comb
    begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        case (state_reg)
            S_A_INC:  begin alu_a = tmp_reg;  alu_b = DP_W'(1);             end
            S_A_CLP:  begin alu_a = tmp_reg;  alu_b = next_ext; alu_sub = 1'b1; end
            S_A_MAX:  begin alu_a = base_ext; alu_b = tmp_reg;  alu_sub = 1'b1; end
            S_L_WIN:  begin alu_a = base_ext; alu_b = win_eff;              end
            S_L_TOT:  begin alu_a = tot_ext;  alu_b = DP_W'(1);             end
            S_L_MIN:  begin alu_a = tmp_reg;  alu_b = lim_reg;  alu_sub = 1'b1; end
            S_L_CNT:  begin alu_a = lim_reg;  alu_b = f_ext;    alu_sub = 1'b1; end
            S_L_DONE: begin alu_a = base_ext; alu_b = tmp_reg;  alu_sub = 1'b1; end
            S_EMIT:   begin alu_a = f_ext;    alu_b = DP_W'(1);             end
            default:  begin alu_a = '0;       alu_b = '0;                   end
        endcase
    end

    gbn_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .res (alu_res),
        .lt  (alu_lt)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        base_next   = base_reg;
        next_next   = next_reg;
        active_next = active_reg;
        tmp_next    = tmp_reg;
        lim_next    = lim_reg;
        f_next      = f_reg;
        cnt_next    = cnt_reg;
        resend_next = resend_reg;
        done_next   = done_reg;
        ob_load     = 1'b0;
        ob_data     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    // Ignored events default to an empty run: lim == f
                    resend_next = 1'b0;
                    f_next      = next_reg;
                    lim_next    = next_ext;
                    state_next  = S_L_TOT;
                    case (in_data.func)
                        FUNC_START:
                        begin
                            base_next   = BASE_W'(1);
                            next_next   = BASE_W'(1);
                            f_next      = BASE_W'(1);
                            active_next = 1'b1;
                            state_next  = S_L_WIN;
                        end
                        FUNC_ACK:
                        begin
                            if (active_reg)
                            begin
                                tmp_next   = {{(DP_W-SEQ_BITS){1'b0}}, in_data.ack_number};
                                state_next = S_A_INC;
                            end
                        end
                        FUNC_TIMEOUT:
                        begin
                            if (active_reg)
                            begin
                                f_next      = base_reg;
                                resend_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            state_next = S_L_TOT;
                        end
                    endcase
                end
            end
            S_A_INC:
            begin
                tmp_next   = alu_res;
                state_next = S_A_CLP;
            end
            S_A_CLP:
            begin
                // Clamp ack + 1 to next: an ACK past the last sent frame
                if (!alu_lt)
                begin
                    tmp_next = next_ext;
                end
                state_next = S_A_MAX;
            end
            S_A_MAX:
            begin
                // Slide base only forward; a stale ACK leaves it
                if (alu_lt)
                begin
                    base_next = tmp_reg[BASE_W-1:0];
                end
                state_next = S_L_WIN;
            end
            S_L_WIN:
            begin
                lim_next   = alu_res;
                f_next     = next_reg;
                state_next = S_L_TOT;
            end
            S_L_TOT:
            begin
                tmp_next   = alu_res;
                state_next = S_L_MIN;
            end
            S_L_MIN:
            begin
                if (alu_lt)
                begin
                    lim_next = tmp_reg;
                end
                state_next = S_L_CNT;
            end
            S_L_CNT:
            begin
                if (alu_lt)
                begin
                    cnt_next = '0;
                end
                else if (alu_res > DP_W'(WINDOW_MAX))
                begin
                    cnt_next = CNT_W'(WINDOW_MAX);
                end
                else
                begin
                    cnt_next = alu_res[CNT_W-1:0];
                end
                state_next = S_L_DONE;
            end
            S_L_DONE:
            begin
                // Done when base >= total + 1, only inside a transfer
                done_next  = active_reg & ~alu_lt;
                state_next = (cnt_reg == '0) ? S_STATUS : S_EMIT;
            end
            S_EMIT:
            begin
                if (ob_free)
                begin
                    ob_load               = 1'b1;
                    ob_data.frame_valid   = 1'b1;
                    ob_data.frame_number  = f_reg[SEQ_BITS-1:0];
                    ob_data.is_resend     = resend_reg;
                    ob_data.window_base   = base_reg;
                    ob_data.transfer_done = done_reg;
                    ob_data.last          = (cnt_reg == CNT_W'(1));
                    f_next                = alu_res[BASE_W-1:0];
                    if (!resend_reg)
                    begin
                        next_next = alu_res[BASE_W-1:0];
                    end
                    cnt_next = cnt_reg - CNT_W'(1);
                    if (cnt_reg == CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_STATUS:
            begin
                if (ob_free)
                begin
                    ob_load               = 1'b1;
                    ob_data.window_base   = base_reg;
                    ob_data.transfer_done = done_reg;
                    ob_data.last          = 1'b1;
                    state_next            = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            base_reg   <= BASE_W'(1);
            next_reg   <= BASE_W'(1);
            active_reg <= 1'b0;
            cnt_reg    <= '0;
            resend_reg <= 1'b0;
            done_reg   <= 1'b0;
            total_reg  <= '0;
            window_reg <= WINDOW_RESET;
        end
        else
        begin
            state_reg  <= state_next;
            base_reg   <= base_next;
            next_reg   <= next_next;
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            resend_reg <= resend_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_index == CFG_TOTAL)
            begin
                total_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == CFG_WINDOW)
            begin
                window_reg <= cfg_data[WIN_W-1:0];
            end
        end
    end

    // Scratch datapath registers
    always_ff @(posedge clk)
    begin
        tmp_reg <= tmp_next;
        lim_reg <= lim_next;
        f_reg   <= f_next;
    end

    gbn_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (ob_load),
        .load_data (ob_data),
        .free      (ob_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

@@ hdl/gbn_chk.sv @@
// Port-level checker for the Go-Back-N sender sequencer, bound to the top level.
module gbn_chk
    import gbn_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input gbn_in_t              in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input gbn_out_t             out_data,
    input logic                 cfg_valid,
    input logic                 cfg_ready,
    input logic [CFG_IDX_W-1:0] cfg_index,
    input logic [SEQ_BITS-1:0]  cfg_data
);

    // Hold a stalled result beat
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // Busy the cycle after an event is taken
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("event taken while a previous one is in progress");

    // A status beat carries no frame and closes its event
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.frame_valid |->
            out_data.last && !out_data.is_resend && out_data.frame_number == '0)
        else $error("malformed status beat");

    // Base never drops to zero
    a_base: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.window_base != '0)
        else $error("window base reported as zero");

endmodule

bind go_back_n_arq_sender gbn_chk u_gbn_chk (.*);
